>>> sv/pntp_pkg.sv
`default_nettype none

package pntp_pkg;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    localparam logic [1:0] PHASE_DOLLAR  = 2'd0;
    localparam logic [1:0] PHASE_HASH    = 2'd1;
    localparam logic [1:0] PHASE_PERCENT = 2'd2;
    localparam logic [1:0] PHASE_DIGITS  = 2'd3;

    localparam logic [2:0] COUNT_MAX   = 3'd4;
    localparam logic [2:0] COUNT_QUOTE = 3'd2;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

endpackage

`default_nettype wire

>>> sv/pntp_digit.sv
`default_nettype none

module pntp_digit (
    input  wire logic [7:0]      ch,
    input  wire logic [1:0]      radix,
    output pntp_pkg::digit_t     digit
);

    logic       is_dec;
    logic       is_upper;
    logic       is_lower;
    logic [7:0] dec_off;
    logic [7:0] upper_off;
    logic [7:0] lower_off;

    assign is_dec    = (ch >= pntp_pkg::CH_ZERO) && (ch <= pntp_pkg::CH_NINE);
    assign is_upper  = (ch >= pntp_pkg::CH_UPPER_A) && (ch <= pntp_pkg::CH_UPPER_F);
    assign is_lower  = (ch >= pntp_pkg::CH_LOWER_A) && (ch <= pntp_pkg::CH_LOWER_F);
    assign dec_off   = ch - pntp_pkg::CH_ZERO;
    assign upper_off = ch - pntp_pkg::CH_UPPER_A + 8'd10;
    assign lower_off = ch - pntp_pkg::CH_LOWER_A + 8'd10;

    always_comb
    begin
        digit.ok  = 1'b0;
        digit.val = dec_off[3:0];
        unique case (radix)
            pntp_pkg::RADIX_BIN:
            begin
                digit.ok = (ch == pntp_pkg::CH_ZERO) || (ch == pntp_pkg::CH_ONE);
            end
            pntp_pkg::RADIX_HEX:
            begin
                if (is_dec)
                begin
                    digit.ok = 1'b1;
                end
                else if (is_upper)
                begin
                    digit.ok  = 1'b1;
                    digit.val = upper_off[3:0];
                end
                else if (is_lower)
                begin
                    digit.ok  = 1'b1;
                    digit.val = lower_off[3:0];
                end
            end
            default:
            begin
                digit.ok = is_dec;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/prefixed_number_token_parser.sv
// Parses one token, a character per beat with tlast on its final character, into a 16-bit
// number. A token quote, c, quote gives the code of c sign-extended; otherwise optional
// prefixes '$' (hex), '#' (decimal), '%' (binary) in that order select the base, decimal by
// default, and the digits build value * base + digit modulo 2^16. One result beat follows each
// tlast beat, with tuser high if the token is a number (tdata is then the value, else zero).
// A beat is taken every cycle; a result is presented once its last character has passed from
// the input register into the result register, and the block stalls only while the result
// register holds a beat not yet taken.
`default_nettype none

module prefixed_number_token_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] value
    output logic             m_tuser    // [0] is_number
);

    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        in_last_reg;

    logic [2:0]  count_reg,  count_next;
    logic [1:0]  phase_reg,  phase_next;
    logic [1:0]  radix_reg,  radix_next;
    logic [15:0] acc_reg,    acc_next;
    logic        bad_reg,    bad_next;
    logic [7:0]  first_reg,  first_next;
    logic [7:0]  second_reg, second_next;

    logic        out_valid_reg;
    logic        out_num_reg,   out_num_next;
    logic [15:0] out_value_reg, out_value_next;

    logic        advance;
    logic        consumed;
    logic        busy;
    logic [15:0] scaled;
    logic [15:0] acc_digit;

    pntp_pkg::digit_t digit;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign busy     = advance && in_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_num_reg;

    pntp_digit u_digit (
        .ch    (in_ch_reg),
        .radix (radix_reg),
        .digit (digit)
    );

    always_comb
    begin
        unique case (radix_reg)
            pntp_pkg::RADIX_HEX: scaled = {acc_reg[11:0], 4'b0000};
            pntp_pkg::RADIX_BIN: scaled = {acc_reg[14:0], 1'b0};
            default:             scaled = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0};
        endcase
        acc_digit = scaled + {12'd0, digit.val};
    end

    always_comb
    begin
        count_next  = (count_reg < pntp_pkg::COUNT_MAX) ? count_reg + 3'd1 : count_reg;
        first_next  = (count_reg == 3'd0) ? in_ch_reg : first_reg;
        second_next = (count_reg == 3'd1) ? in_ch_reg : second_reg;
        phase_next  = phase_reg;
        radix_next  = radix_reg;
        consumed    = 1'b0;

        if (phase_next == pntp_pkg::PHASE_DOLLAR)
        begin
            phase_next = pntp_pkg::PHASE_HASH;
            if (in_ch_reg == pntp_pkg::CH_DOLLAR)
            begin
                radix_next = pntp_pkg::RADIX_HEX;
                consumed   = 1'b1;
            end
        end
        if (!consumed && phase_next == pntp_pkg::PHASE_HASH)
        begin
            phase_next = pntp_pkg::PHASE_PERCENT;
            if (in_ch_reg == pntp_pkg::CH_HASH)
            begin
                radix_next = pntp_pkg::RADIX_DEC;
                consumed   = 1'b1;
            end
        end
        if (!consumed && phase_next == pntp_pkg::PHASE_PERCENT)
        begin
            phase_next = pntp_pkg::PHASE_DIGITS;
            if (in_ch_reg == pntp_pkg::CH_PERCENT)
            begin
                radix_next = pntp_pkg::RADIX_BIN;
                consumed   = 1'b1;
            end
        end

        acc_next = acc_reg;
        bad_next = bad_reg;
        if (!consumed)
        begin
            if (digit.ok)
            begin
                acc_next = acc_digit;
            end
            else
            begin
                bad_next = 1'b1;
            end
        end

        priority if (count_reg == pntp_pkg::COUNT_QUOTE && first_reg == pntp_pkg::CH_QUOTE
                     && in_ch_reg == pntp_pkg::CH_QUOTE)
        begin
            out_num_next   = 1'b1;
            out_value_next = {{8{second_reg[7]}}, second_reg};
        end
        else if (bad_next)
        begin
            out_num_next   = 1'b0;
            out_value_next = 16'd0;
        end
        else
        begin
            out_num_next   = 1'b1;
            out_value_next = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= 3'd0;
            phase_reg     <= pntp_pkg::PHASE_DOLLAR;
            radix_reg     <= pntp_pkg::RADIX_DEC;
            acc_reg       <= 16'd0;
            bad_reg       <= 1'b0;
            first_reg     <= 8'd0;
            second_reg    <= 8'd0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && in_last_reg;
            end
            if (busy)
            begin
                // clear the token state once its last character is in
                if (in_last_reg)
                begin
                    count_reg  <= 3'd0;
                    phase_reg  <= pntp_pkg::PHASE_DOLLAR;
                    radix_reg  <= pntp_pkg::RADIX_DEC;
                    acc_reg    <= 16'd0;
                    bad_reg    <= 1'b0;
                    first_reg  <= 8'd0;
                    second_reg <= 8'd0;
                end
                else
                begin
                    count_reg  <= count_next;
                    phase_reg  <= phase_next;
                    radix_reg  <= radix_next;
                    acc_reg    <= acc_next;
                    bad_reg    <= bad_next;
                    first_reg  <= first_next;
                    second_reg <= second_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (busy && in_last_reg)
        begin
            out_num_reg   <= out_num_next;
            out_value_reg <= out_value_next;
        end
    end

endmodule

`default_nettype wire
